[hw/rtl/sfepf_pkg.sv]
package sfepf_pkg;

    localparam int PAGE_BYTES       = 256;
    localparam int PAGES_PER_SECTOR = 16;
    localparam int MAX_COUNT        = 32768;

    localparam int PAGE_W     = 18;
    localparam int OFFSET_W   = 8;
    localparam int COUNT_W    = 16;
    localparam int BYTE_W     = 8;
    localparam int CHUNK_W    = 9;
    localparam int SECTOR_SHIFT = $clog2(PAGES_PER_SECTOR);
    localparam int SECTOR_W   = PAGE_W - SECTOR_SHIFT;
    localparam int SPAN_W     = 4;
    localparam int ADDR_W     = 32;

    // item kinds
    localparam logic ITEM_START = 1'b0;
    localparam logic ITEM_DATA  = 1'b1;

    // flash command opcodes
    localparam logic [BYTE_W-1:0] CMD_WREN     = 8'h06;
    localparam logic [BYTE_W-1:0] CMD_WRDI     = 8'h04;
    localparam logic [BYTE_W-1:0] CMD_PP3      = 8'h02;
    localparam logic [BYTE_W-1:0] CMD_PP4      = 8'h12;
    localparam logic [BYTE_W-1:0] CMD_SE3      = 8'h20;
    localparam logic [BYTE_W-1:0] CMD_SE4      = 8'h21;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DECODE,
        ST_E_WREN,
        ST_E_OPC,
        ST_E_A3,
        ST_E_A2,
        ST_E_A1,
        ST_E_A0,
        ST_E_WRDI,
        ST_P_WREN,
        ST_P_OPC,
        ST_P_A3,
        ST_P_A2,
        ST_P_A1,
        ST_P_A0,
        ST_P_DATA,
        ST_P_WRDI
    } state_t;

    typedef enum logic [3:0] {
        SEL_WREN,
        SEL_WRDI,
        SEL_ERASE,
        SEL_PROG,
        SEL_ADDR3,
        SEL_ADDR2,
        SEL_ADDR1,
        SEL_ADDR0,
        SEL_DATA
    } byte_sel_t;

    typedef struct packed {
        logic      capture;
        logic      start_load;
        logic      chunk_open;
        logic      data_step;
        logic      sector_step;
        logic      emit;
        byte_sel_t sel;
        logic      addr_sector;
        logic      frame_end;
        logic      last;
    } ctrl_cmd_t;

    typedef struct packed {
        logic item_is_data;
        logic busy;
        logic count_zero;
        logic chunk_active;
        logic chunk_last;
        logic sectors_more;
        logic four_byte;
        logic out_free;
    } dp_status_t;

endpackage

[hw/rtl/sfepf_dp.sv]
module sfepf_dp #(
    parameter int MAX_COUNT = sfepf_pkg::MAX_COUNT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    input  logic                                 cfg_four_byte_addressing,
    input  logic                                 opcode,
    input  logic [sfepf_pkg::PAGE_W-1:0]         page,
    input  logic [sfepf_pkg::OFFSET_W-1:0]       offset,
    input  logic [sfepf_pkg::COUNT_W-1:0]        count,
    input  logic [sfepf_pkg::BYTE_W-1:0]         data_byte,
    input  logic                                 out_stall,
    input  sfepf_pkg::ctrl_cmd_t                 cmd,
    output sfepf_pkg::dp_status_t                status,
    output logic                                 out_valid,
    output logic [sfepf_pkg::BYTE_W-1:0]         spi_byte,
    output logic                                 frame_end,
    output logic                                 last
);

    logic                               four_byte_reg;
    logic                               item_op_reg;
    logic [sfepf_pkg::PAGE_W-1:0]       item_page_reg;
    logic [sfepf_pkg::OFFSET_W-1:0]     item_offset_reg;
    logic [sfepf_pkg::COUNT_W-1:0]      item_count_reg;
    logic [sfepf_pkg::BYTE_W-1:0]       item_data_reg;

    logic                               busy_reg, busy_next;
    logic [sfepf_pkg::PAGE_W-1:0]       page_reg, page_next;
    logic [sfepf_pkg::OFFSET_W-1:0]     pos_reg, pos_next;
    logic [sfepf_pkg::COUNT_W-1:0]      total_reg, total_next;
    logic [sfepf_pkg::CHUNK_W-1:0]      chunk_reg, chunk_next;
    logic [sfepf_pkg::SECTOR_W-1:0]     sector_reg, sector_next;
    logic [sfepf_pkg::SPAN_W-1:0]       sectors_left_reg, sectors_left_next;

    logic                               out_valid_reg, out_valid_next;
    logic [sfepf_pkg::BYTE_W-1:0]       spi_byte_reg, spi_byte_next;
    logic                               frame_end_reg;
    logic                               last_reg;

    logic [sfepf_pkg::COUNT_W-1:0]      count_clamped;
    logic [sfepf_pkg::COUNT_W:0]        span_bytes;
    logic [sfepf_pkg::PAGE_W:0]         end_page;
    logic [sfepf_pkg::SECTOR_W:0]       sector_diff;
    logic [sfepf_pkg::CHUNK_W-1:0]      room;
    logic [sfepf_pkg::CHUNK_W-1:0]      chunk_size;
    logic [sfepf_pkg::ADDR_W-1:0]       addr_word;
    logic                               out_free;

    // first-write extent: clamp count, find the last page touched and the sector span
    always_comb
    begin
        if (item_count_reg > sfepf_pkg::COUNT_W'(MAX_COUNT))
            count_clamped = sfepf_pkg::COUNT_W'(MAX_COUNT);
        else
            count_clamped = item_count_reg;
        span_bytes  = {1'b0, count_clamped}
                    + (sfepf_pkg::COUNT_W+1)'(item_offset_reg)
                    - (sfepf_pkg::COUNT_W+1)'(1);
        end_page    = {1'b0, item_page_reg}
                    + (sfepf_pkg::PAGE_W+1)'(span_bytes[sfepf_pkg::COUNT_W:sfepf_pkg::OFFSET_W]);
        sector_diff = end_page[sfepf_pkg::PAGE_W:sfepf_pkg::SECTOR_SHIFT]
                    - {1'b0, item_page_reg[sfepf_pkg::PAGE_W-1:sfepf_pkg::SECTOR_SHIFT]};
    end

    // bytes that fit before the next page boundary
    always_comb
    begin
        room = sfepf_pkg::CHUNK_W'(sfepf_pkg::PAGE_BYTES) - sfepf_pkg::CHUNK_W'(pos_reg);
        if (total_reg < sfepf_pkg::COUNT_W'(room))
            chunk_size = total_reg[sfepf_pkg::CHUNK_W-1:0];
        else
            chunk_size = room;
    end

    always_comb
    begin
        busy_next         = busy_reg;
        page_next         = page_reg;
        pos_next          = pos_reg;
        total_next        = total_reg;
        chunk_next        = chunk_reg;
        sector_next       = sector_reg;
        sectors_left_next = sectors_left_reg;

        if (cmd.start_load)
        begin
            busy_next         = 1'b1;
            page_next         = item_page_reg;
            pos_next          = item_offset_reg;
            total_next        = count_clamped;
            chunk_next        = '0;
            sector_next       = item_page_reg[sfepf_pkg::PAGE_W-1:sfepf_pkg::SECTOR_SHIFT];
            sectors_left_next = sector_diff[sfepf_pkg::SPAN_W-1:0];
        end

        if (cmd.chunk_open)
            chunk_next = chunk_size;

        if (cmd.data_step)
        begin
            chunk_next = chunk_reg - sfepf_pkg::CHUNK_W'(1);
            total_next = total_reg - sfepf_pkg::COUNT_W'(1);
            pos_next   = pos_reg + sfepf_pkg::OFFSET_W'(1);
            busy_next  = (total_reg != sfepf_pkg::COUNT_W'(1));
            // wrapping past the page end always closes the chunk
            if (pos_reg == {sfepf_pkg::OFFSET_W{1'b1}})
                page_next = page_reg + sfepf_pkg::PAGE_W'(1);
        end

        if (cmd.sector_step)
        begin
            sector_next       = sector_reg + sfepf_pkg::SECTOR_W'(1);
            sectors_left_next = sectors_left_reg - sfepf_pkg::SPAN_W'(1);
        end
    end

    always_comb
    begin
        if (cmd.addr_sector)
            addr_word = {6'b0, sector_reg, 12'b0};
        else
            addr_word = {6'b0, page_reg, pos_reg};
    end

    always_comb
    begin
        case (cmd.sel)
            sfepf_pkg::SEL_WREN:  spi_byte_next = sfepf_pkg::CMD_WREN;
            sfepf_pkg::SEL_WRDI:  spi_byte_next = sfepf_pkg::CMD_WRDI;
            sfepf_pkg::SEL_ERASE: spi_byte_next = four_byte_reg ? sfepf_pkg::CMD_SE4
                                                                : sfepf_pkg::CMD_SE3;
            sfepf_pkg::SEL_PROG:  spi_byte_next = four_byte_reg ? sfepf_pkg::CMD_PP4
                                                                : sfepf_pkg::CMD_PP3;
            sfepf_pkg::SEL_ADDR3: spi_byte_next = addr_word[31:24];
            sfepf_pkg::SEL_ADDR2: spi_byte_next = addr_word[23:16];
            sfepf_pkg::SEL_ADDR1: spi_byte_next = addr_word[15:8];
            sfepf_pkg::SEL_ADDR0: spi_byte_next = addr_word[7:0];
            sfepf_pkg::SEL_DATA:  spi_byte_next = item_data_reg;
            default:              spi_byte_next = item_data_reg;
        endcase
    end

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        if (cmd.emit)
            out_valid_next = 1'b1;
        else if (out_stall)
            out_valid_next = out_valid_reg;
        else
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            four_byte_reg    <= 1'b0;
            busy_reg         <= 1'b0;
            page_reg         <= '0;
            pos_reg          <= '0;
            total_reg        <= '0;
            chunk_reg        <= '0;
            sector_reg       <= '0;
            sectors_left_reg <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
                four_byte_reg <= cfg_four_byte_addressing;
            busy_reg         <= busy_next;
            page_reg         <= page_next;
            pos_reg          <= pos_next;
            total_reg        <= total_next;
            chunk_reg        <= chunk_next;
            sector_reg       <= sector_next;
            sectors_left_reg <= sectors_left_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_op_reg     <= opcode;
            item_page_reg   <= page;
            item_offset_reg <= offset;
            item_count_reg  <= count;
            item_data_reg   <= data_byte;
        end
        if (cmd.emit)
        begin
            spi_byte_reg  <= spi_byte_next;
            frame_end_reg <= cmd.frame_end;
            last_reg      <= cmd.last;
        end
    end

    always_comb
    begin
        status.item_is_data = (item_op_reg == sfepf_pkg::ITEM_DATA);
        status.busy         = busy_reg;
        status.count_zero   = (item_count_reg == '0);
        status.chunk_active = (chunk_reg != '0);
        status.chunk_last   = (chunk_reg == sfepf_pkg::CHUNK_W'(1));
        status.sectors_more = (sectors_left_reg != '0);
        status.four_byte    = four_byte_reg;
        status.out_free     = out_free;
    end

    assign out_valid = out_valid_reg;
    assign spi_byte  = spi_byte_reg;
    assign frame_end = frame_end_reg;
    assign last      = last_reg;

endmodule

[hw/rtl/sfepf_ctrl.sv]
module sfepf_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  sfepf_pkg::dp_status_t  status,
    output sfepf_pkg::ctrl_cmd_t   cmd
);

    sfepf_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= sfepf_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        in_stall        = 1'b1;
        cmd.capture     = 1'b0;
        cmd.start_load  = 1'b0;
        cmd.chunk_open  = 1'b0;
        cmd.data_step   = 1'b0;
        cmd.sector_step = 1'b0;
        cmd.emit        = 1'b0;
        cmd.sel         = sfepf_pkg::SEL_WREN;
        cmd.addr_sector = 1'b0;
        cmd.frame_end   = 1'b0;
        cmd.last        = 1'b0;

        case (state_reg)
            sfepf_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = sfepf_pkg::ST_DECODE;
                end
            end

            sfepf_pkg::ST_DECODE:
            begin
                if (!status.item_is_data)
                begin
                    // drop a start while busy or with nothing to write
                    if (status.busy || status.count_zero)
                        state_next = sfepf_pkg::ST_IDLE;
                    else
                    begin
                        cmd.start_load = 1'b1;
                        state_next     = sfepf_pkg::ST_E_WREN;
                    end
                end
                else if (!status.busy)
                    state_next = sfepf_pkg::ST_IDLE;
                else if (status.chunk_active)
                    state_next = sfepf_pkg::ST_P_DATA;
                else
                begin
                    cmd.chunk_open = 1'b1;
                    state_next     = sfepf_pkg::ST_P_WREN;
                end
            end

            sfepf_pkg::ST_E_WREN:
            begin
                cmd.sel       = sfepf_pkg::SEL_WREN;
                cmd.frame_end = 1'b1;
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = sfepf_pkg::ST_E_OPC;
                end
            end

            sfepf_pkg::ST_E_OPC:
            begin
                cmd.sel = sfepf_pkg::SEL_ERASE;
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = status.four_byte ? sfepf_pkg::ST_E_A3 : sfepf_pkg::ST_E_A2;
                end
            end

            sfepf_pkg::ST_E_A3:
            begin
                cmd.sel         = sfepf_pkg::SEL_ADDR3;
                cmd.addr_sector = 1'b1;
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = sfepf_pkg::ST_E_A2;
                end
            end

            sfepf_pkg::ST_E_A2:
            begin
                cmd.sel         = sfepf_pkg::SEL_ADDR2;
                cmd.addr_sector = 1'b1;
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = sfepf_pkg::ST_E_A1;
                end
            end

            sfepf_pkg::ST_E_A1:
            begin
                cmd.sel         = sfepf_pkg::SEL_ADDR1;
                cmd.addr_sector = 1'b1;
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = sfepf_pkg::ST_E_A0;
                end
            end

            sfepf_pkg::ST_E_A0:
            begin
                cmd.sel         = sfepf_pkg::SEL_ADDR0;
                cmd.addr_sector = 1'b1;
                cmd.frame_end   = 1'b1;
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = sfepf_pkg::ST_E_WRDI;
                end
            end

            sfepf_pkg::ST_E_WRDI:
            begin
                cmd.sel       = sfepf_pkg::SEL_WRDI;
                cmd.frame_end = 1'b1;
                cmd.last      = !status.sectors_more;
                if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                    // advance to the next sector or finish the start transaction
                    if (status.sectors_more)
                    begin
                        cmd.sector_step = 1'b1;
                        state_next      = sfepf_pkg::ST_E_WREN;
                    end
                    else
                        state_next = sfepf_pkg::ST_IDLE;
                end
            end

            sfepf_pkg::ST_P_WREN:
            begin
                cmd.sel       = sfepf_pkg::SEL_WREN;
                cmd.frame_end = 1'b1;
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = sfepf_pkg::ST_P_OPC;
                end
            end

            sfepf_pkg::ST_P_OPC:
            begin
                cmd.sel = sfepf_pkg::SEL_PROG;
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = status.four_byte ? sfepf_pkg::ST_P_A3 : sfepf_pkg::ST_P_A2;
                end
            end

            sfepf_pkg::ST_P_A3:
            begin
                cmd.sel = sfepf_pkg::SEL_ADDR3;
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = sfepf_pkg::ST_P_A2;
                end
            end

            sfepf_pkg::ST_P_A2:
            begin
                cmd.sel = sfepf_pkg::SEL_ADDR2;
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = sfepf_pkg::ST_P_A1;
                end
            end

            sfepf_pkg::ST_P_A1:
            begin
                cmd.sel = sfepf_pkg::SEL_ADDR1;
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = sfepf_pkg::ST_P_A0;
                end
            end

            sfepf_pkg::ST_P_A0:
            begin
                cmd.sel = sfepf_pkg::SEL_ADDR0;
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = sfepf_pkg::ST_P_DATA;
                end
            end

            sfepf_pkg::ST_P_DATA:
            begin
                cmd.sel       = sfepf_pkg::SEL_DATA;
                cmd.frame_end = status.chunk_last;
                cmd.last      = !status.chunk_last;
                if (status.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.data_step = 1'b1;
                    state_next    = status.chunk_last ? sfepf_pkg::ST_P_WRDI
                                                      : sfepf_pkg::ST_IDLE;
                end
            end

            sfepf_pkg::ST_P_WRDI:
            begin
                cmd.sel       = sfepf_pkg::SEL_WRDI;
                cmd.frame_end = 1'b1;
                cmd.last      = 1'b1;
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = sfepf_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = sfepf_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

[hw/rtl/spi_flash_erase_and_program_framer_core.sv]
// channel   signals                                   direction  transaction when
// input     in_valid, in_stall, opcode, page, offset,  in         in_valid && !in_stall
//           count, data_byte
// output    out_valid, out_stall, spi_byte,            out        out_valid && !out_stall
//           frame_end, last
// config    cfg_valid, cfg_ready,                      in         cfg_valid && cfg_ready
//           cfg_four_byte_addressing
//
// One item at a time: accept, a decode state, then one SPI byte per cycle into the
// output register while the output is not stalled.
// The single output register sets the rate; an output stall holds the sequencer.
// Reset (rst_n low) clears the sequencer, write progress and the addressing mode.
module spi_flash_erase_and_program_framer_core #(
    parameter int MAX_COUNT = sfepf_pkg::MAX_COUNT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic                                 cfg_four_byte_addressing,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 opcode,
    input  logic [sfepf_pkg::PAGE_W-1:0]         page,
    input  logic [sfepf_pkg::OFFSET_W-1:0]       offset,
    input  logic [sfepf_pkg::COUNT_W-1:0]        count,
    input  logic [sfepf_pkg::BYTE_W-1:0]         data_byte,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [sfepf_pkg::BYTE_W-1:0]         spi_byte,
    output logic                                 frame_end,
    output logic                                 last
);

    sfepf_pkg::ctrl_cmd_t  cmd;
    sfepf_pkg::dp_status_t status;

    assign cfg_ready = 1'b1;

    sfepf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    sfepf_dp #(
        .MAX_COUNT (MAX_COUNT)
    ) u_dp (
        .clk                      (clk),
        .rst_n                    (rst_n),
        .cfg_valid                (cfg_valid),
        .cfg_four_byte_addressing (cfg_four_byte_addressing),
        .opcode                   (opcode),
        .page                     (page),
        .offset                   (offset),
        .count                    (count),
        .data_byte                (data_byte),
        .out_stall                (out_stall),
        .cmd                      (cmd),
        .status                   (status),
        .out_valid                (out_valid),
        .spi_byte                 (spi_byte),
        .frame_end                (frame_end),
        .last                     (last)
    );

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

    localparam int HOLD_CYCLES   = 200;
    localparam int SETTLE_CYCLES = 80;

    typedef struct packed {
        logic [sfepf_pkg::BYTE_W-1:0] value;
        logic                         frame_end;
        logic                         last;
    } spi_beat_t;

    typedef enum logic [1:0] {
        RX_FREE,
        RX_HALF,
        RX_QUARTER,
        RX_EVERY_FOURTH
    } rx_pattern_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic                           cfg_four_byte_addressing = 1'b0;
    logic                           in_valid = 1'b0;
    logic                           in_stall;
    logic                           opcode = sfepf_pkg::ITEM_START;
    logic [sfepf_pkg::PAGE_W-1:0]   page = '0;
    logic [sfepf_pkg::OFFSET_W-1:0] offset = '0;
    logic [sfepf_pkg::COUNT_W-1:0]  count = '0;
    logic [sfepf_pkg::BYTE_W-1:0]   data_byte = '0;
    logic                           out_valid;
    logic                           out_stall = 1'b0;
    logic [sfepf_pkg::BYTE_W-1:0]   spi_byte;
    logic                           frame_end;
    logic                           last;

    // predicted flash state
    logic                           addr4_mode = 1'b0;
    logic                           wr_busy = 1'b0;
    logic [sfepf_pkg::PAGE_W-1:0]   wr_page = '0;
    logic [sfepf_pkg::OFFSET_W-1:0] wr_pos = '0;
    logic [sfepf_pkg::COUNT_W-1:0]  wr_left = '0;
    logic [sfepf_pkg::CHUNK_W-1:0]  chunk_left = '0;

    spi_beat_t                      spi_bytes_due[$];
    int                             mismatch_count = 0;
    int                             burst_left = 0;

    logic                           hold_toggle = 1'b0;
    logic                           hold_seen = 1'b0;
    int                             hold_left = 0;
    rx_pattern_t                    rx_pattern = RX_FREE;
    int                             rx_pattern_left = 0;

    spi_flash_erase_and_program_framer_core dut (
        .clk                      (clk),
        .rst_n                    (rst_n),
        .cfg_valid                (cfg_valid),
        .cfg_ready                (cfg_ready),
        .cfg_four_byte_addressing (cfg_four_byte_addressing),
        .in_valid                 (in_valid),
        .in_stall                 (in_stall),
        .opcode                   (opcode),
        .page                     (page),
        .offset                   (offset),
        .count                    (count),
        .data_byte                (data_byte),
        .out_valid                (out_valid),
        .out_stall                (out_stall),
        .spi_byte                 (spi_byte),
        .frame_end                (frame_end),
        .last                     (last)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic void push_beat(input logic [sfepf_pkg::BYTE_W-1:0] value,
                                      input logic fe, input logic fin);
        spi_beat_t b;
        b.value     = value;
        b.frame_end = fe;
        b.last      = fin;
        spi_bytes_due.push_back(b);
    endfunction

    // big-endian; 3-byte mode drops everything above bit 23
    function automatic void push_address(input logic [sfepf_pkg::ADDR_W-1:0] addr,
                                         input logic fe);
        if (addr4_mode)
            push_beat(addr[31:24], 1'b0, 1'b0);
        push_beat(addr[23:16], 1'b0, 1'b0);
        push_beat(addr[15:8], 1'b0, 1'b0);
        push_beat(addr[7:0], fe, 1'b0);
    endfunction

    function automatic void frame_spi_bytes(input logic op,
                                            input logic [sfepf_pkg::PAGE_W-1:0] pg,
                                            input logic [sfepf_pkg::OFFSET_W-1:0] off,
                                            input logic [sfepf_pkg::COUNT_W-1:0] cnt,
                                            input logic [sfepf_pkg::BYTE_W-1:0] d);
        int unsigned                    n_bytes;
        int unsigned                    end_page;
        int unsigned                    first_sec;
        int unsigned                    last_sec;
        int unsigned                    s;
        logic [sfepf_pkg::SECTOR_W-1:0] sec;
        logic [sfepf_pkg::CHUNK_W-1:0]  room;
        logic                           chunk_done;
        if (op == sfepf_pkg::ITEM_START)
        begin
            if (wr_busy || cnt == 0)
                return;
            n_bytes   = (cnt > sfepf_pkg::MAX_COUNT) ? sfepf_pkg::MAX_COUNT : cnt;
            end_page  = pg + (n_bytes + off - 1) / sfepf_pkg::PAGE_BYTES;
            first_sec = pg / sfepf_pkg::PAGES_PER_SECTOR;
            last_sec  = end_page / sfepf_pkg::PAGES_PER_SECTOR;
            // sector numbers wrap past the top of the device
            for (s = first_sec; s <= last_sec; s++)
            begin
                sec = sfepf_pkg::SECTOR_W'(s);
                push_beat(sfepf_pkg::CMD_WREN, 1'b1, 1'b0);
                push_beat(addr4_mode ? sfepf_pkg::CMD_SE4 : sfepf_pkg::CMD_SE3, 1'b0, 1'b0);
                push_address(sfepf_pkg::ADDR_W'({sec, 12'h000}), 1'b1);
                push_beat(sfepf_pkg::CMD_WRDI, 1'b1, s == last_sec);
            end
            wr_busy    = 1'b1;
            wr_page    = pg;
            wr_pos     = off;
            wr_left    = sfepf_pkg::COUNT_W'(n_bytes);
            chunk_left = '0;
        end
        else if (wr_busy)
        begin
            if (chunk_left == 0)
            begin
                room       = sfepf_pkg::CHUNK_W'(sfepf_pkg::PAGE_BYTES) - {1'b0, wr_pos};
                chunk_left = (wr_left < room) ? wr_left[sfepf_pkg::CHUNK_W-1:0] : room;
                push_beat(sfepf_pkg::CMD_WREN, 1'b1, 1'b0);
                push_beat(addr4_mode ? sfepf_pkg::CMD_PP4 : sfepf_pkg::CMD_PP3, 1'b0, 1'b0);
                push_address(sfepf_pkg::ADDR_W'({wr_page, wr_pos}), 1'b0);
            end
            chunk_left--;
            wr_left--;
            wr_pos++;
            chunk_done = (chunk_left == 0);
            push_beat(d, chunk_done, !chunk_done);
            if (chunk_done)
            begin
                push_beat(sfepf_pkg::CMD_WRDI, 1'b1, 1'b1);
                if (wr_pos == 0)
                    wr_page++;
            end
            wr_busy = (wr_left != 0);
        end
    endfunction

    always @(posedge clk)
    begin : check_spi
        spi_beat_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (spi_bytes_due.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: spi byte %02h end %0b last %0b with nothing outstanding",
                             $realtime, spi_byte, frame_end, last);
            end
            else
            begin
                want = spi_bytes_due.pop_front();
                if (spi_byte !== want.value || frame_end !== want.frame_end ||
                    last !== want.last)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: spi mismatch: want %02h/%0b/%0b got %02h/%0b/%0b",
                                 $realtime, want.value, want.frame_end, want.last,
                                 spi_byte, frame_end, last);
                end
            end
        end
    end

    // receiver: own stall pattern, plus a long hold-off on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall       <= 1'b0;
            hold_seen       <= 1'b0;
            hold_left       <= 0;
            rx_pattern      <= RX_FREE;
            rx_pattern_left <= 0;
        end
        else if (hold_toggle != hold_seen)
        begin
            hold_seen <= hold_toggle;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            if (rx_pattern_left == 0)
            begin
                rx_pattern      <= rx_pattern_t'($urandom_range(0, 3));
                rx_pattern_left <= $urandom_range(10, 60);
            end
            else
            begin
                rx_pattern_left <= rx_pattern_left - 1;
            end
            case (rx_pattern)
                RX_FREE:         out_stall <= 1'b0;
                RX_HALF:         out_stall <= ($urandom_range(0, 1) == 0);
                RX_QUARTER:      out_stall <= ($urandom_range(0, 3) == 0);
                RX_EVERY_FOURTH: out_stall <= (rx_pattern_left[1:0] == 2'd0);
                default:         out_stall <= 1'b0;
            endcase
        end
    end

    task automatic send_item(input logic op, input logic [sfepf_pkg::PAGE_W-1:0] pg,
                             input logic [sfepf_pkg::OFFSET_W-1:0] off,
                             input logic [sfepf_pkg::COUNT_W-1:0] cnt,
                             input logic [sfepf_pkg::BYTE_W-1:0] d);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid  <= 1'b1;
        opcode    <= op;
        page      <= pg;
        offset    <= off;
        count     <= cnt;
        data_byte <= d;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        frame_spi_bytes(op, pg, off, cnt, d);
    endtask

    task automatic send_start(input logic [sfepf_pkg::PAGE_W-1:0] pg,
                              input logic [sfepf_pkg::OFFSET_W-1:0] off,
                              input logic [sfepf_pkg::COUNT_W-1:0] cnt);
        send_item(sfepf_pkg::ITEM_START, pg, off, cnt, sfepf_pkg::BYTE_W'($urandom));
    endtask

    task automatic send_data(input logic [sfepf_pkg::BYTE_W-1:0] d);
        send_item(sfepf_pkg::ITEM_DATA, sfepf_pkg::PAGE_W'($urandom),
                  sfepf_pkg::OFFSET_W'($urandom), sfepf_pkg::COUNT_W'($urandom), d);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (spi_bytes_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_addr_mode(input logic mode);
        wait_drained();
        // let any transaction that emits nothing run out before touching the mode
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid                <= 1'b1;
        cfg_four_byte_addressing <= mode;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid  <= 1'b0;
        addr4_mode = mode;
    endtask

    task automatic test_idle_inputs();
        send_data(8'hFF);
        send_start({sfepf_pkg::PAGE_W{1'b1}}, 8'hFF, 16'd0);
        send_data(8'h00);
    endtask

    task automatic test_single_byte();
        send_start('0, 8'h00, 16'd1);
        send_data(8'h00);
    endtask

    task automatic test_page_crossing();
        send_start(18'h00015, 8'hFE, 16'd4);
        send_data(8'hA5);
        // a start in the middle of a write is dropped
        send_start(sfepf_pkg::PAGE_W'($urandom), sfepf_pkg::OFFSET_W'($urandom), 16'hFFFF);
        send_data(8'h5A);
        send_data(8'hFF);
        send_data(8'h00);
    endtask

    task automatic test_address_wrap();
        write_addr_mode(1'b1);
        send_start({sfepf_pkg::PAGE_W{1'b1}}, 8'd250, 16'd8);
        for (int i = 0; i < 8; i++)
            send_data(sfepf_pkg::BYTE_W'($urandom));
        write_addr_mode(1'b0);
        send_start({sfepf_pkg::PAGE_W{1'b1}}, 8'd255, 16'd2);
        send_data(8'hC3);
        send_data(8'h3C);
    endtask

    task automatic test_output_holdoff();
        hold_toggle <= ~hold_toggle;
        send_start(sfepf_pkg::PAGE_W'($urandom), 8'd240, 16'd24);
        for (int i = 0; i < 24; i++)
            send_data(sfepf_pkg::BYTE_W'($urandom));
    endtask

    task automatic test_drain_pause();
        send_start(sfepf_pkg::PAGE_W'($urandom), sfepf_pkg::OFFSET_W'($urandom), 16'd10);
        for (int i = 0; i < 5; i++)
            send_data(sfepf_pkg::BYTE_W'($urandom));
        wait_drained();
        for (int i = 0; i < 5; i++)
            send_data(sfepf_pkg::BYTE_W'($urandom));
    endtask

    task automatic test_random_writes(input int target);
        int                             sent;
        int                             n;
        int                             kind;
        logic [sfepf_pkg::PAGE_W-1:0]   pg;
        logic [sfepf_pkg::OFFSET_W-1:0] off;
        sent = 0;
        while (sent < target)
        begin
            n    = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
            kind = $urandom_range(0, 5);
            case (kind)
                0:
                    pg = {sfepf_pkg::PAGE_W{1'b1}}
                       - sfepf_pkg::PAGE_W'($urandom_range(0, 2));
                1:
                    pg = sfepf_pkg::PAGE_W'($urandom_range(0, 2)
                                            * sfepf_pkg::PAGES_PER_SECTOR + 15);
                default:
                    pg = sfepf_pkg::PAGE_W'($urandom);
            endcase
            off = (kind <= 2) ? sfepf_pkg::OFFSET_W'(256 - $urandom_range(1, 8))
                              : sfepf_pkg::OFFSET_W'($urandom);
            send_start(pg, off, sfepf_pkg::COUNT_W'(n));
            for (int i = 0; i < n; i++)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_start(sfepf_pkg::PAGE_W'($urandom), sfepf_pkg::OFFSET_W'($urandom),
                               sfepf_pkg::COUNT_W'($urandom));
                send_data(sfepf_pkg::BYTE_W'($urandom));
            end
            sent += n + 1;
            // noise while idle
            if ($urandom_range(0, 4) == 0)
                send_data(sfepf_pkg::BYTE_W'($urandom));
            if ($urandom_range(0, 6) == 0)
                send_start(sfepf_pkg::PAGE_W'($urandom), sfepf_pkg::OFFSET_W'($urandom),
                           16'd0);
        end
    endtask

    task automatic test_count_clamp();
        write_addr_mode(1'b1);
        // widest erase span: nine sectors with four-byte addresses
        send_start(18'd15, 8'hFF, 16'hFFFF);
        send_data(8'h81);
        send_data(8'h7E);
        send_data(sfepf_pkg::BYTE_W'($urandom));
        send_start(sfepf_pkg::PAGE_W'($urandom), sfepf_pkg::OFFSET_W'($urandom), 16'd1);
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_idle_inputs();
        test_single_byte();
        test_page_crossing();
        test_address_wrap();
        test_output_holdoff();
        test_drain_pause();
        write_addr_mode(1'b1);
        test_random_writes(20);
        write_addr_mode(1'b0);
        test_random_writes(20);
        write_addr_mode(1'($urandom_range(0, 1)));
        test_random_writes(15);
        test_count_clamp();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && spi_bytes_due.size() == 0)
            $display("spi_flash_erase_and_program_framer_core verification clean");
        else
            $display("spi_flash_erase_and_program_framer_core verification failed");
        $finish;
    end

    initial
    begin
        #4_000_000;
        $display("spi_flash_erase_and_program_framer_core verification failed");
        $finish;
    end

endmodule
